@@ src/xbr_pkg.sv @@
// ----------------------------------------------------------------------------
// xbr_pkg
// Shared types, codes and the CRC-16/XMODEM byte step for the block receiver.
// ----------------------------------------------------------------------------
package xbr_pkg;

    localparam int LONG_PAYLOAD_DEF  = 1024;
    localparam int SHORT_PAYLOAD_DEF = 128;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int LEN_W       = 11;
    localparam int IDX_W       = 10;

    localparam logic [7:0]  TYPE_SOH  = 8'h01;
    localparam logic [7:0]  TYPE_STX  = 8'h02;
    localparam logic [7:0]  TYPE_EOT  = 8'h04;
    localparam logic [LEN_W-1:0] HDR_LEN = LEN_W'(3);
    localparam logic [11:0] LIMIT_MAX = 12'd2048;
    localparam logic [11:0] LIMIT_RST = 12'd1030;
    localparam logic [15:0] CRC_POLY  = 16'h1021;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHECK_MODE   = 2'd0,
        REG_BUFFER_LIMIT = 2'd1,
        REG_UNUSED_2     = 2'd2,
        REG_UNUSED_3     = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        CMD_APPEND  = 2'd0,
        CMD_COMMIT  = 2'd1,
        CMD_RETRY   = 2'd2,
        CMD_RESTART = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ST_NEED_MORE   = 4'd0,
        ST_BLOCK_READY = 4'd1,
        ST_DONE        = 4'd2,
        ST_NOT_OK      = 4'd3,
        ST_WRITTEN     = 4'd4,
        ST_DUPLICATE   = 4'd5,
        ST_INVALID     = 4'd6,
        ST_BAD_MSG     = 4'd7,
        ST_CLEARED     = 4'd8
    } t_status;

    typedef struct packed {
        logic [LEN_W-1:0] frame_length;
        logic [7:0]       frame_type;
        logic [7:0]       header_block;
        logic [7:0]       header_complement;
        logic [15:0]      crc_acc;
        logic [7:0]       sum_acc;
        logic [15:0]      trailer_bytes;
    } t_frame;

    typedef struct packed {
        t_status          status;
        logic             payload_valid;
        logic [IDX_W-1:0] payload_index;
        logic [7:0]       payload_byte;
        logic [7:0]       block_number;
    } t_result;

    function automatic logic [15:0] crc_step(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

@@ src/xbr_if.sv @@
// ----------------------------------------------------------------------------
// xbr_if
// Valid/ready channels of the block receiver: byte input, result, config.
// ----------------------------------------------------------------------------
interface xbr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] data_byte;
    logic       chunk_end;

    modport source (output valid, cmd, data_byte, chunk_end, input ready);
    modport sink   (input valid, cmd, data_byte, chunk_end, output ready);
endinterface

interface xbr_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] status;
    logic       payload_valid;
    logic [9:0] payload_index;
    logic [7:0] payload_byte;
    logic [7:0] block_number;

    modport source (output valid, status, payload_valid, payload_index, payload_byte,
                    block_number, input ready);
    modport sink   (input valid, status, payload_valid, payload_index, payload_byte,
                    block_number, output ready);
endinterface

interface xbr_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [11:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ src/xbr_frame.sv @@
// ----------------------------------------------------------------------------
// xbr_frame
// Per-item frame logic: next frame state, expected block and the result.
// ----------------------------------------------------------------------------
module xbr_frame #(
    parameter int LONG_PAYLOAD  = xbr_pkg::LONG_PAYLOAD_DEF,
    parameter int SHORT_PAYLOAD = xbr_pkg::SHORT_PAYLOAD_DEF
) (
    input  xbr_pkg::t_frame  i_frame,
    input  logic [7:0]       i_expected,
    input  logic             i_check_mode,
    input  logic [11:0]      i_buffer_limit,
    input  xbr_pkg::t_cmd    i_cmd,
    input  logic [7:0]       i_data_byte,
    input  logic             i_chunk_end,
    output xbr_pkg::t_frame  o_frame,
    output logic [7:0]       o_expected,
    output xbr_pkg::t_result o_result
);
    import xbr_pkg::*;

    localparam logic [LEN_W-1:0] SHORT_LEN = LEN_W'(SHORT_PAYLOAD);
    localparam logic [LEN_W-1:0] LONG_LEN  = LEN_W'(LONG_PAYLOAD);

    function automatic logic [LEN_W-1:0] payload_len(input logic [7:0] t);
        logic [LEN_W-1:0] l;
        l = '0;
        if (t == TYPE_SOH) l = SHORT_LEN;
        else if (t == TYPE_STX) l = LONG_LEN;
        return l;
    endfunction

    logic [11:0]      lim;
    logic [LEN_W-1:0] pos;
    logic [LEN_W-1:0] bl;
    logic [LEN_W-1:0] bl_new;
    logic [LEN_W-1:0] trl;
    logic             check_ok;

    always_comb begin
        lim      = (i_buffer_limit > LIMIT_MAX) ? LIMIT_MAX : i_buffer_limit;
        pos      = i_frame.frame_length;
        bl       = payload_len(i_frame.frame_type);
        trl      = i_check_mode ? LEN_W'(2) : LEN_W'(1);
        check_ok = i_check_mode ? (i_frame.crc_acc == i_frame.trailer_bytes)
                                : (i_frame.sum_acc == i_frame.trailer_bytes[15:8]);
        o_frame    = i_frame;
        o_expected = i_expected;
        bl_new     = '0;
        o_result   = '{status: ST_NEED_MORE, payload_valid: 1'b0, payload_index: '0,
                       payload_byte: '0, block_number: i_frame.header_block};

        unique case (i_cmd)
            CMD_APPEND: begin
                if (({1'b0, pos} + 12'd1) < lim) begin
                    if (pos == '0) begin
                        o_frame            = '0;
                        o_frame.frame_type = i_data_byte;
                    end else if (pos == LEN_W'(1)) begin
                        o_frame.header_block = i_data_byte;
                    end else if (pos == LEN_W'(2)) begin
                        o_frame.header_complement = i_data_byte;
                    end else if (pos < HDR_LEN + bl) begin
                        o_frame.crc_acc        = crc_step(i_frame.crc_acc, i_data_byte);
                        o_frame.sum_acc        = i_frame.sum_acc + i_data_byte;
                        o_result.payload_valid = 1'b1;
                        o_result.payload_index = IDX_W'(pos - HDR_LEN);
                        o_result.payload_byte  = i_data_byte;
                    end else if (pos == HDR_LEN + bl && bl != '0) begin
                        o_frame.trailer_bytes = {i_data_byte, 8'h00};
                    end else if (pos == HDR_LEN + bl + LEN_W'(1) && bl != '0) begin
                        o_frame.trailer_bytes = {i_frame.trailer_bytes[15:8], i_data_byte};
                    end
                    o_frame.frame_length = pos + LEN_W'(1);
                    bl_new = payload_len(o_frame.frame_type);
                    // a frame is judged only on the last byte of a chunk
                    if (i_chunk_end) begin
                        if (bl_new != '0) begin
                            if (o_frame.frame_length < HDR_LEN)
                                o_result.status = ST_NEED_MORE;
                            else if (o_frame.header_complement == ~o_frame.header_block)
                                o_result.status =
                                    (o_frame.frame_length < HDR_LEN + bl_new + trl)
                                    ? ST_NEED_MORE : ST_BLOCK_READY;
                            else
                                o_result.status = ST_NOT_OK;
                        end else if (o_frame.frame_type == TYPE_EOT &&
                                     o_frame.frame_length == LEN_W'(1)) begin
                            o_result.status = ST_DONE;
                        end else begin
                            o_result.status = ST_NOT_OK;
                        end
                    end
                end else begin
                    o_result.status = ST_NOT_OK;
                end
                o_result.block_number = o_frame.header_block;
            end
            CMD_COMMIT: begin
                if (bl == '0 || pos < HDR_LEN + bl + trl) begin
                    o_result.status = ST_INVALID;
                end else if (!check_ok) begin
                    o_result.status = ST_BAD_MSG;
                end else if (i_expected == i_frame.header_block) begin
                    o_result.status = ST_WRITTEN;
                    o_expected      = i_expected + 8'd1;
                    o_frame         = '0;
                end else if (i_expected == i_frame.header_block + 8'd1) begin
                    o_result.status = ST_DUPLICATE;
                    o_frame         = '0;
                end else begin
                    o_result.status = ST_BAD_MSG;
                end
            end
            CMD_RETRY: begin
                o_frame               = '0;
                o_result.status       = ST_CLEARED;
                o_result.block_number = '0;
            end
            CMD_RESTART: begin
                o_frame               = '0;
                o_expected            = 8'd1;
                o_result.status       = ST_CLEARED;
                o_result.block_number = '0;
            end
            default: begin
                o_frame = i_frame;
            end
        endcase
    end

endmodule

@@ src/xmodem_block_receiver_top.sv @@
// ----------------------------------------------------------------------------
// xmodem_block_receiver_top
// XMODEM frame receiver: header, payload tagging, CRC-16 or sum, sequencing.
// ----------------------------------------------------------------------------
// Each accepted transaction (append byte, commit, retry or restart) yields
// exactly one result, captured in the output register and valid from the next cycle. A new
// transaction is taken every cycle while the result register is empty or
// its result is taken in the same cycle, so the sustained rate is one item
// per clock; the figure is set by the update of the frame registers for each
// accepted item, whose longest path is the eight-bit CRC-16 step per byte.
// Configuration writes are always ready and should only be issued while idle.
module xmodem_block_receiver_top #(
    parameter int LONG_PAYLOAD  = xbr_pkg::LONG_PAYLOAD_DEF,
    parameter int SHORT_PAYLOAD = xbr_pkg::SHORT_PAYLOAD_DEF
) (
    input logic       i_clk,
    input logic       i_rst_n,
    xbr_in_if.sink    i_in,
    xbr_out_if.source o_out,
    xbr_cfg_if.sink   i_cfg
);
    import xbr_pkg::*;

    logic        r_check_mode;
    logic [11:0] r_buffer_limit;
    t_frame      r_frame;
    t_frame      n_frame;
    logic [7:0]  r_expected;
    logic [7:0]  n_expected;
    logic        r_out_valid;
    t_result     r_out;
    t_result     n_out;
    logic        in_accept;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_accept   = i_in.valid && i_in.ready;

    xbr_frame #(
        .LONG_PAYLOAD  (LONG_PAYLOAD),
        .SHORT_PAYLOAD (SHORT_PAYLOAD)
    ) u_frame (
        .i_frame        (r_frame),
        .i_expected     (r_expected),
        .i_check_mode   (r_check_mode),
        .i_buffer_limit (r_buffer_limit),
        .i_cmd          (t_cmd'(i_in.cmd)),
        .i_data_byte    (i_in.data_byte),
        .i_chunk_end    (i_in.chunk_end),
        .o_frame        (n_frame),
        .o_expected     (n_expected),
        .o_result       (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_mode   <= 1'b1;
            r_buffer_limit <= LIMIT_RST;
        end else if (i_cfg.valid) begin
            unique case (t_reg_idx'(i_cfg.index))
                REG_CHECK_MODE:   r_check_mode   <= i_cfg.data[0];
                REG_BUFFER_LIMIT: r_buffer_limit <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame     <= '0;
            r_expected  <= 8'd1;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_frame     <= n_frame;
                r_expected  <= n_expected;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_out.status;
    assign o_out.payload_valid = r_out.payload_valid;
    assign o_out.payload_index = r_out.payload_index;
    assign o_out.payload_byte  = r_out.payload_byte;
    assign o_out.block_number  = r_out.block_number;

`ifndef SYNTH
    // an accepted transaction always leaves a result behind
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_out_valid)
        else $error("accepted transaction produced no result");

    // an empty frame always carries cleared accumulators
    a_empty_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_frame.frame_length == '0) |->
        (r_frame.frame_type == '0 && r_frame.crc_acc == '0 && r_frame.sum_acc == '0))
        else $error("empty frame holds stale state");

    // a tagged payload byte only comes with an append status
    a_payload_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.payload_valid) |->
        (r_out.status == ST_NEED_MORE || r_out.status == ST_BLOCK_READY ||
         r_out.status == ST_NOT_OK))
        else $error("payload byte with non-append status");
`endif

endmodule

@@ dv/tb_xmodem_block_receiver_top.sv @@
// ----------------------------------------------------------------------------
// tb_xmodem_block_receiver_top
// Self-checking bench for the XMODEM block receiver: drives framed byte
// streams and commands with random idling, predicts every response in a
// cycle-free model of the frame logic and compares it field by field.
// ----------------------------------------------------------------------------
module tb_xmodem_block_receiver_top;
    timeunit 1ns;
    timeprecision 1ps;

    import xbr_pkg::*;

    localparam int LONG_BYTES     = LONG_PAYLOAD_DEF;
    localparam int SHORT_BYTES    = SHORT_PAYLOAD_DEF;
    localparam int HDR_BYTES      = int'(HDR_LEN);
    localparam int HOLDOFF_CYCLES = 400;
    localparam int QUIET_LIMIT    = 5000;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] data;
        logic       last;
    } t_xfer_item;

    logic i_clk;
    logic i_rst_n;

    xbr_in_if  in_ch();
    xbr_out_if out_ch();
    xbr_cfg_if cfg_ch();

    xmodem_block_receiver_top #(
        .LONG_PAYLOAD (LONG_BYTES),
        .SHORT_PAYLOAD(SHORT_BYTES)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // frame model state
    bit          model_crc_mode;
    logic [11:0] model_limit;
    logic [10:0] rx_len;
    logic [7:0]  rx_type;
    logic [7:0]  rx_blk;
    logic [7:0]  rx_cmp;
    logic [15:0] rx_crc;
    logic [7:0]  rx_sum;
    logic [15:0] rx_trailer;
    logic [7:0]  rx_expected;

    t_xfer_item rx_commands[$];
    t_result    predicted_responses[$];
    int         mismatch_count;

    // stimulus side
    bit         gaps_on;
    int         holdoff_req;
    int         gen_items;
    bit         gen_crc;
    logic [7:0] gen_next_blk;

    // driver and monitor side
    t_xfer_item offered;
    t_result    predicted;
    t_result    expected_rsp;
    int         send_gap;
    int         stall_cnt;
    int         hold_cnt;
    int         holdoff_served;
    logic       next_ready;

    function automatic logic [15:0] crc16_next(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc;
        // bit-serial form, msb first
        for (int k = 7; k >= 0; k--) begin
            c = (c[15] ^ b[k]) ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    function automatic int payload_bytes(logic [7:0] t);
        if (t == TYPE_SOH) return SHORT_BYTES;
        if (t == TYPE_STX) return LONG_BYTES;
        return 0;
    endfunction

    function automatic void clear_frame_model();
        rx_len     = '0;
        rx_type    = '0;
        rx_blk     = '0;
        rx_cmp     = '0;
        rx_crc     = '0;
        rx_sum     = '0;
        rx_trailer = '0;
    endfunction

    function automatic t_result frame_step(t_cmd c, logic [7:0] b, logic last);
        t_result r;
        int      lim;
        int      pos;
        int      plen;
        int      tlen;
        r        = '0;
        r.status = ST_NEED_MORE;
        tlen     = model_crc_mode ? 2 : 1;
        case (c)
            CMD_APPEND: begin
                lim = (model_limit > LIMIT_MAX) ? int'(LIMIT_MAX) : int'(model_limit);
                pos = int'(rx_len);
                if (pos + 1 < lim) begin
                    if (pos == 0) begin
                        clear_frame_model();
                        rx_type = b;
                    end else if (pos == 1) begin
                        rx_blk = b;
                    end else if (pos == 2) begin
                        rx_cmp = b;
                    end else begin
                        plen = payload_bytes(rx_type);
                        if (pos < HDR_BYTES + plen) begin
                            rx_crc          = crc16_next(rx_crc, b);
                            rx_sum          = rx_sum + b;
                            r.payload_valid = 1'b1;
                            r.payload_index = IDX_W'(pos - HDR_BYTES);
                            r.payload_byte  = b;
                        end else if (plen != 0 && pos == HDR_BYTES + plen) begin
                            rx_trailer = {b, 8'h00};
                        end else if (plen != 0 && pos == HDR_BYTES + plen + 1) begin
                            rx_trailer[7:0] = b;
                        end
                        // anything past the trailer only bumps the length
                    end
                    rx_len = LEN_W'(pos + 1);
                    plen   = payload_bytes(rx_type);
                    if (!last) begin
                        r.status = ST_NEED_MORE;
                    end else if (plen != 0) begin
                        if (pos + 1 < HDR_BYTES)
                            r.status = ST_NEED_MORE;
                        else if (rx_cmp == ~rx_blk)
                            r.status = (pos + 1 < HDR_BYTES + plen + tlen) ?
                                       ST_NEED_MORE : ST_BLOCK_READY;
                        else
                            r.status = ST_NOT_OK;
                    end else if (rx_type == TYPE_EOT && pos == 0) begin
                        r.status = ST_DONE;
                    end else begin
                        r.status = ST_NOT_OK;
                    end
                end else begin
                    // buffer full, byte dropped
                    r.status = ST_NOT_OK;
                end
                r.block_number = rx_blk;
            end
            CMD_COMMIT: begin
                plen           = payload_bytes(rx_type);
                r.block_number = rx_blk;
                if (plen == 0 || int'(rx_len) < HDR_BYTES + plen + tlen) begin
                    r.status = ST_INVALID;
                end else if (model_crc_mode ? (rx_crc != rx_trailer) :
                                              (rx_sum != rx_trailer[15:8])) begin
                    r.status = ST_BAD_MSG;
                end else if (rx_expected == rx_blk) begin
                    r.status    = ST_WRITTEN;
                    rx_expected = rx_expected + 8'd1;
                    clear_frame_model();
                end else if (rx_expected == 8'(rx_blk + 8'd1)) begin
                    r.status = ST_DUPLICATE;
                    clear_frame_model();
                end else begin
                    r.status = ST_BAD_MSG;
                end
            end
            default: begin
                clear_frame_model();
                if (c == CMD_RESTART) rx_expected = 8'd1;
                r.status       = ST_CLEARED;
                r.block_number = rx_blk;
            end
        endcase
        return r;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // sender: holds an item until it is taken, predicts it on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predicted = frame_step(offered.cmd, offered.data, offered.last);
                predicted_responses.push_back(predicted);
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_ch.valid <= 1'b0;
                end else if (rx_commands.size() > 0) begin
                    offered = rx_commands.pop_front();
                    in_ch.valid     <= 1'b1;
                    in_ch.cmd       <= offered.cmd;
                    in_ch.data_byte <= offered.data;
                    in_ch.chunk_end <= offered.last;
                    if (gaps_on && $urandom_range(0, 99) < 25) send_gap = idle_len();
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each response transaction, stalls at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_cnt = 0;
            hold_cnt  = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (predicted_responses.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("[%0t] unexpected response, status=%0d blk=%02h", $realtime,
                                 out_ch.status, out_ch.block_number);
                end else begin
                    expected_rsp = predicted_responses.pop_front();
                    if (out_ch.status !== expected_rsp.status ||
                        out_ch.payload_valid !== expected_rsp.payload_valid ||
                        out_ch.payload_index !== expected_rsp.payload_index ||
                        out_ch.payload_byte !== expected_rsp.payload_byte ||
                        out_ch.block_number !== expected_rsp.block_number) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display({"[%0t] mismatch: expected st=%0d pv=%0b",
                                      " idx=%0d byte=%02h blk=%02h"},
                                     $realtime, expected_rsp.status,
                                     expected_rsp.payload_valid,
                                     expected_rsp.payload_index,
                                     expected_rsp.payload_byte,
                                     expected_rsp.block_number);
                            $display({"             actual   st=%0d pv=%0b",
                                      " idx=%0d byte=%02h blk=%02h"},
                                     out_ch.status, out_ch.payload_valid,
                                     out_ch.payload_index, out_ch.payload_byte,
                                     out_ch.block_number);
                        end
                    end
                end
            end
            if (holdoff_served != holdoff_req) begin
                holdoff_served++;
                hold_cnt = HOLDOFF_CYCLES;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                next_ready = 1'b0;
            end else if (stall_cnt > 0) begin
                stall_cnt--;
                next_ready = 1'b0;
            end else begin
                next_ready = 1'b1;
                if (gaps_on && $urandom_range(0, 99) < 20) stall_cnt = idle_len();
            end
            out_ch.ready <= next_ready;
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TEST FAILED");
        $finish;
    end

    task automatic push_item(t_cmd c, logic [7:0] d, logic e);
        t_xfer_item it;
        it.cmd  = c;
        it.data = d;
        it.last = e;
        rx_commands.push_back(it);
        gen_items++;
    endtask

    task automatic write_reg(t_reg_idx idx, logic [11:0] value);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        if (idx == REG_CHECK_MODE) model_crc_mode = value[0];
        else if (idx == REG_BUFFER_LIMIT) model_limit = value;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (rx_commands.size() != 0 || in_ch.valid === 1'b1 ||
               predicted_responses.size() != 0);
        repeat (3) @(posedge i_clk);
    endtask

    // one well-formed frame with random content, sometimes damaged, then commits, a retry or both
    task automatic queue_frame(bit long_frame, bit tight);
        logic [7:0]  fb[$];
        logic [15:0] crc;
        logic [7:0]  sum;
        logic [7:0]  blk;
        logic [7:0]  b;
        int          plen;
        int          r;
        int          cut;
        bit          tainted;
        plen    = long_frame ? LONG_BYTES : SHORT_BYTES;
        tainted = tight;
        r       = $urandom_range(0, 99);
        if (r < 75) begin
            blk = gen_next_blk;
        end else if (r < 87) begin
            blk = gen_next_blk - 8'd1;
        end else begin
            blk     = 8'($urandom);
            tainted = 1'b1;
        end
        if ($urandom_range(0, 99) < 95) begin
            fb.push_back(long_frame ? TYPE_STX : TYPE_SOH);
        end else begin
            fb.push_back(8'($urandom));
            tainted = 1'b1;
        end
        fb.push_back(blk);
        if ($urandom_range(0, 99) < 6) begin
            fb.push_back(~blk ^ 8'($urandom_range(1, 255)));
            tainted = 1'b1;
        end else begin
            fb.push_back(~blk);
        end
        crc = '0;
        sum = '0;
        for (int i = 0; i < plen; i++) begin
            b = 8'($urandom);
            fb.push_back(b);
            crc = crc16_next(crc, b);
            sum = sum + b;
        end
        if (gen_crc) begin
            fb.push_back(crc[15:8]);
            fb.push_back(crc[7:0]);
        end else begin
            fb.push_back(sum);
        end
        if ($urandom_range(0, 99) < 6) begin
            cut = $urandom_range(HDR_BYTES, fb.size() - 1);
            fb[cut] = fb[cut] ^ (8'h01 << $urandom_range(0, 7));
            tainted = 1'b1;
        end
        if ($urandom_range(0, 99) < 5) begin
            cut = $urandom_range(1, fb.size() - 1);
            while (fb.size() > cut) void'(fb.pop_back());
            tainted = 1'b1;
        end else if ($urandom_range(0, 99) < 5) begin
            repeat ($urandom_range(1, 3)) fb.push_back(8'($urandom));
        end
        foreach (fb[i]) begin
            push_item(CMD_APPEND, fb[i], (i == fb.size() - 1) ?
                      ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0));
        end
        r = $urandom_range(0, 99);
        if (r < 88) begin
            push_item(CMD_COMMIT, 8'($urandom), 1'($urandom));
            if (r >= 82) push_item(CMD_COMMIT, 8'($urandom), 1'($urandom));
            if (!tainted && blk == gen_next_blk) gen_next_blk = gen_next_blk + 8'd1;
        end
        if (tainted || r >= 88 || $urandom_range(0, 99) < 8)
            push_item(CMD_RETRY, 8'($urandom), 1'($urandom));
    endtask

    task automatic queue_traffic(int budget, int long_pct, bit tight);
        int first_item;
        int r;
        t_cmd c;
        first_item   = gen_items;
        gen_crc      = model_crc_mode;
        gen_next_blk = rx_expected;
        while (gen_items - first_item < budget) begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
                c = t_cmd'($urandom_range(0, 3));
                push_item(c, 8'($urandom), 1'($urandom));
                if (c == CMD_RESTART) gen_next_blk = 8'd1;
                if (c == CMD_APPEND && $urandom_range(0, 1))
                    push_item(CMD_RETRY, 8'($urandom), 1'($urandom));
            end else if (r < 8) begin
                // end of transfer, then a fresh one
                push_item(CMD_APPEND, TYPE_EOT, 1'b1);
                push_item(CMD_RESTART, 8'($urandom), 1'($urandom));
                gen_next_blk = 8'd1;
            end else if (r < 10) begin
                push_item(CMD_RESTART, 8'($urandom), 1'($urandom));
                gen_next_blk = 8'd1;
            end else begin
                queue_frame($urandom_range(0, 99) < long_pct, tight);
            end
        end
    endtask

    initial begin
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.cmd        = CMD_APPEND;
        in_ch.data_byte  = 8'h00;
        in_ch.chunk_end  = 1'b0;
        out_ch.ready     = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = REG_CHECK_MODE;
        cfg_ch.data      = '0;
        model_crc_mode   = 1'b1;
        model_limit      = LIMIT_RST;
        clear_frame_model();
        rx_expected      = 8'd1;
        mismatch_count   = 0;
        holdoff_req      = 0;
        holdoff_served   = 0;
        gen_items        = 0;
        gaps_on          = 1'b1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: lone EOT, EOT with trailing byte, bad type, bad complement,
        // short frame commits, retry and restart, field extremes
        push_item(CMD_APPEND, TYPE_EOT, 1'b1);
        push_item(CMD_APPEND, 8'h00, 1'b1);
        push_item(CMD_COMMIT, 8'h00, 1'b0);
        push_item(CMD_RETRY, 8'hFF, 1'b1);
        push_item(CMD_COMMIT, 8'hFF, 1'b1);
        push_item(CMD_APPEND, TYPE_SOH, 1'b0);
        push_item(CMD_APPEND, 8'h07, 1'b1);
        push_item(CMD_APPEND, 8'h07, 1'b1);
        push_item(CMD_COMMIT, 8'h00, 1'b0);
        push_item(CMD_RESTART, 8'h55, 1'b0);
        push_item(CMD_APPEND, TYPE_STX, 1'b0);
        push_item(CMD_APPEND, 8'h00, 1'b0);
        push_item(CMD_APPEND, 8'hFF, 1'b1);
        push_item(CMD_APPEND, 8'hFF, 1'b1);
        push_item(CMD_APPEND, 8'h00, 1'b0);
        push_item(CMD_COMMIT, 8'hAA, 1'b1);
        push_item(CMD_RETRY, 8'h00, 1'b0);
        push_item(CMD_APPEND, 8'hFF, 1'b1);
        push_item(CMD_APPEND, 8'h00, 1'b0);
        push_item(CMD_RETRY, 8'h00, 1'b0);
        push_item(CMD_APPEND, 8'h03, 1'b1);
        push_item(CMD_RESTART, 8'hFF, 1'b1);
        wait_drained();

        queue_traffic(100, 0, 1'b0);
        wait_drained();

        // sum trailer, no idling, long receiver hold-off
        gaps_on = 1'b0;
        write_reg(REG_CHECK_MODE, 12'd0);
        write_reg(REG_BUFFER_LIMIT, 12'd2048);
        queue_traffic(100, 0, 1'b0);
        holdoff_req++;
        wait_drained();

        // limit above the cap
        gaps_on = 1'b1;
        write_reg(REG_CHECK_MODE, 12'd1);
        write_reg(REG_BUFFER_LIMIT, 12'hFFF);
        queue_traffic(100, 0, 1'b0);
        wait_drained();

        // every append dropped
        write_reg(REG_CHECK_MODE, 12'd0);
        write_reg(REG_BUFFER_LIMIT, 12'd1);
        queue_traffic(30, 0, 1'b1);
        wait_drained();

        write_reg(REG_CHECK_MODE, 12'd1);
        write_reg(REG_BUFFER_LIMIT, 12'd0);
        write_reg(REG_UNUSED_2, 12'($urandom));
        write_reg(REG_UNUSED_3, 12'($urandom));
        queue_traffic(30, 0, 1'b1);
        wait_drained();

        // short frames overflow the buffer
        write_reg(REG_BUFFER_LIMIT, 12'd130);
        queue_traffic(100, 0, 1'b1);
        wait_drained();

        // short frame with sum trailer fits with no byte to spare
        write_reg(REG_CHECK_MODE, 12'd0);
        write_reg(REG_BUFFER_LIMIT, 12'd133);
        queue_traffic(100, 0, 1'b0);
        wait_drained();

        // long frame with crc trailer fits with no byte to spare
        gaps_on = 1'b0;
        write_reg(REG_CHECK_MODE, 12'd1);
        write_reg(REG_BUFFER_LIMIT, LIMIT_RST);
        queue_traffic(1, 100, 1'b0);
        holdoff_req++;
        wait_drained();

        gaps_on = 1'b1;
        write_reg(REG_CHECK_MODE, 12'($urandom_range(0, 1)));
        write_reg(REG_BUFFER_LIMIT, 12'($urandom_range(1, 2048)));
        queue_traffic(100, 0, 1'b0);
        wait_drained();

        write_reg(REG_CHECK_MODE, 12'd1);
        write_reg(REG_BUFFER_LIMIT, LIMIT_MAX);
        queue_traffic(100, 0, 1'b0);
        wait_drained();
        repeat (5) @(posedge i_clk);

        if (mismatch_count == 0 && predicted_responses.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
